// ===== rtl/core/rrts_pkg.sv =====
// Shared types, codes and constants of the round-robin thread scheduler.
package rrts_pkg;

  // Sizes
  localparam int NUM_THREADS_DEF = 16;
  localparam int TID_W           = 4;
  localparam int OP_W            = 3;
  localparam int KIND_W          = 2;
  localparam int STAT_W          = 3;
  localparam int CNT_OUT_W       = 5;
  localparam int ERR_W           = 2;
  localparam int CFG_DATA_W      = 32;
  localparam int CFG_ADDR_W      = 3;

  // Operation codes
  localparam logic [OP_W-1:0] OP_START   = 3'd0;
  localparam logic [OP_W-1:0] OP_YIELD   = 3'd1;
  localparam logic [OP_W-1:0] OP_BLOCK   = 3'd2;
  localparam logic [OP_W-1:0] OP_UNBLOCK = 3'd3;
  localparam logic [OP_W-1:0] OP_EXIT    = 3'd4;

  // Block kind that means nothing
  localparam logic [KIND_W-1:0] KIND_BAD = 2'd3;

  // Thread status codes
  localparam logic [STAT_W-1:0] ST_UNUSED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_READY   = 3'd1;
  localparam logic [STAT_W-1:0] ST_RUNNING = 3'd2;
  localparam logic [STAT_W-1:0] ST_BLOCKED = 3'd3;
  localparam logic [STAT_W-1:0] ST_HANGING = 3'd4;
  localparam logic [STAT_W-1:0] ST_WAITING = 3'd5;
  localparam logic [STAT_W-1:0] ST_DIED    = 3'd6;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_OK     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_STATUS = 2'd1;
  localparam logic [ERR_W-1:0] ERR_BAD    = 2'd2;

  // Register index of the idle thread register
  localparam logic REG_IDLE = 1'b0;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_STAT,
    S_RM_RD,
    S_RM_WR,
    S_RM_END,
    S_SCHED_RD,
    S_SCHED_CHK,
    S_SCHED_POP,
    S_SCHED_SET,
    S_DONE
  } sched_state_t;

endpackage

// ===== rtl/core/rrts_status_mem.sv =====
// Per-thread status store with registered read and reset-time valid bits.
module rrts_status_mem #(
  parameter int NUM_THREADS = rrts_pkg::NUM_THREADS_DEF,
  parameter int IDX_W       = $clog2(NUM_THREADS)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        we,
  input  logic [IDX_W-1:0]            waddr,
  input  logic [rrts_pkg::STAT_W-1:0] wdata,
  input  logic [IDX_W-1:0]            raddr,
  output logic [rrts_pkg::STAT_W-1:0] rdata
);
  import rrts_pkg::*;

  logic [STAT_W-1:0] mem [NUM_THREADS];
  logic [NUM_THREADS-1:0] vld;
  logic [STAT_W-1:0] data_q;
  logic              vld_q;
  logic [IDX_W-1:0]  addr_q;

  // Storage write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    data_q <= mem[raddr];
    addr_q <= raddr;
  end

  // Valid bits: an entry never written reads as its reset status
  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      vld_q <= vld[raddr];
    end
  end

  assign rdata = vld_q ? data_q : ((addr_q == '0) ? ST_RUNNING : ST_UNUSED);

endmodule

// ===== rtl/core/rrts_queue_mem.sv =====
// Circular ready-queue storage, one write and one registered read per cycle.
module rrts_queue_mem #(
  parameter int AW = 4
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [rrts_pkg::TID_W-1:0] wdata,
  input  logic [AW-1:0]              raddr,
  output logic [rrts_pkg::TID_W-1:0] rdata
);
  import rrts_pkg::*;

  localparam int DEPTH = 2 ** AW;

  logic [TID_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/rrts_ctrl.sv =====
// Scheduler sequencer: decodes an operation and walks status and queue stores.
module rrts_ctrl #(
  parameter int NUM_THREADS = rrts_pkg::NUM_THREADS_DEF,
  parameter int IDX_W       = $clog2(NUM_THREADS),
  parameter int CNT_W       = $clog2(NUM_THREADS + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [rrts_pkg::OP_W-1:0]    operation,
  input  logic [rrts_pkg::TID_W-1:0]   thread_id,
  input  logic [rrts_pkg::KIND_W-1:0]  block_kind,
  input  logic                         reschedule,
  input  logic [rrts_pkg::TID_W-1:0]   fallback_tid,
  output logic                         done,
  output logic [rrts_pkg::TID_W-1:0]   active_thread,
  output logic [rrts_pkg::TID_W-1:0]   previous_thread,
  output logic                         switched,
  output logic [rrts_pkg::CNT_OUT_W-1:0] ready_count,
  output logic [rrts_pkg::ERR_W-1:0]   error_code,
  // status store
  output logic                         st_we,
  output logic [IDX_W-1:0]             st_waddr,
  output logic [rrts_pkg::STAT_W-1:0]  st_wdata,
  output logic [IDX_W-1:0]             st_raddr,
  input  logic [rrts_pkg::STAT_W-1:0]  st_rdata,
  // queue store
  output logic                         q_we,
  output logic [IDX_W-1:0]             q_waddr,
  output logic [rrts_pkg::TID_W-1:0]   q_wdata,
  output logic [IDX_W-1:0]             q_raddr,
  input  logic [rrts_pkg::TID_W-1:0]   q_rdata
);
  import rrts_pkg::*;

  sched_state_t state, state_next;

  logic [TID_W-1:0]  cur, cur_next;
  logic [TID_W-1:0]  prev, prev_next;
  logic [OP_W-1:0]   op_q, op_next;
  logic [TID_W-1:0]  tid_q, tid_next;
  logic [KIND_W-1:0] kind_q, kind_next;
  logic              resched_q, resched_next;
  logic [ERR_W-1:0]  err, err_next;
  logic              sw, sw_next;
  logic [IDX_W-1:0]  head, head_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  iter, iter_next;
  logic              found, found_next;

  logic [IDX_W-1:0] tail;
  logic [IDX_W-1:0] tid_idx;
  logic [IDX_W-1:0] cur_idx;
  logic             room;
  logic             bad_item;
  logic [TID_W-1:0] idle_sel;

  assign tail     = head + count[IDX_W-1:0];
  assign tid_idx  = IDX_W'(tid_q);
  assign cur_idx  = IDX_W'(cur);
  assign room     = 32'(count) < NUM_THREADS;
  assign idle_sel = (32'(fallback_tid) < NUM_THREADS) ? fallback_tid : '0;
  assign bad_item = (op_q > OP_EXIT) ||
                    (op_q == OP_BLOCK && kind_q == KIND_BAD) ||
                    ((op_q == OP_START || op_q == OP_UNBLOCK || op_q == OP_EXIT) &&
                     (32'(tid_q) >= NUM_THREADS));

  // State and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cur   <= '0;
      head  <= '0;
      count <= '0;
      sw    <= 1'b0;
      err   <= ERR_OK;
      found <= 1'b0;
      iter  <= '0;
    end else begin
      state <= state_next;
      cur   <= cur_next;
      head  <= head_next;
      count <= count_next;
      sw    <= sw_next;
      err   <= err_next;
      found <= found_next;
      iter  <= iter_next;
    end
  end

  // Latched command beat, no reset needed
  always_ff @(posedge clk) begin
    prev      <= prev_next;
    op_q      <= op_next;
    tid_q     <= tid_next;
    kind_q    <= kind_next;
    resched_q <= resched_next;
  end

  // Next state and store control
  always_comb begin
    state_next   = state;
    cur_next     = cur;
    prev_next    = prev;
    op_next      = op_q;
    tid_next     = tid_q;
    kind_next    = kind_q;
    resched_next = resched_q;
    err_next     = err;
    sw_next      = sw;
    head_next    = head;
    count_next   = count;
    iter_next    = iter;
    found_next   = found;
    st_we        = 1'b0;
    st_waddr     = cur_idx;
    st_wdata     = ST_RUNNING;
    st_raddr     = cur_idx;
    q_we         = 1'b0;
    q_waddr      = tail;
    q_wdata      = tid_q;
    q_raddr      = head;

    case (state)
      S_IDLE: begin
        if (start) begin
          op_next      = operation;
          tid_next     = thread_id;
          kind_next    = block_kind;
          resched_next = reschedule;
          prev_next    = cur;
          err_next     = ERR_OK;
          sw_next      = 1'b0;
          state_next   = S_DECODE;
        end
      end

      // Range checks, then read the status the operation needs
      S_DECODE: begin
        if (bad_item) begin
          err_next   = ERR_BAD;
          state_next = S_DONE;
        end else begin
          st_raddr   = (op_q == OP_YIELD || op_q == OP_BLOCK) ? cur_idx : tid_idx;
          state_next = S_STAT;
        end
      end

      S_STAT: begin
        state_next = S_DONE;
        case (op_q)
          OP_START: begin
            if (st_rdata != ST_UNUSED && st_rdata != ST_DIED) begin
              err_next = ERR_STATUS;
            end else begin
              st_we    = 1'b1;
              st_waddr = tid_idx;
              st_wdata = ST_READY;
              if (room) begin
                q_we       = 1'b1;
                q_waddr    = tail;
                q_wdata    = tid_q;
                count_next = count + 1'b1;
              end
            end
          end
          OP_YIELD: begin
            state_next = S_SCHED_RD;
          end
          OP_BLOCK: begin
            if (st_rdata != ST_RUNNING) begin
              err_next = ERR_STATUS;
            end else begin
              st_we      = 1'b1;
              st_waddr   = cur_idx;
              st_wdata   = ST_BLOCKED + STAT_W'(kind_q);
              state_next = S_SCHED_RD;
            end
          end
          OP_UNBLOCK: begin
            if (st_rdata != ST_BLOCKED && st_rdata != ST_HANGING &&
                st_rdata != ST_WAITING) begin
              err_next = ERR_STATUS;
            end else begin
              st_we    = 1'b1;
              st_waddr = tid_idx;
              st_wdata = ST_READY;
              if (room) begin
                q_we       = 1'b1;
                q_waddr    = head - 1'b1;
                q_wdata    = tid_q;
                head_next  = head - 1'b1;
                count_next = count + 1'b1;
              end
            end
          end
          OP_EXIT: begin
            if (st_rdata == ST_UNUSED || st_rdata == ST_DIED) begin
              err_next = ERR_STATUS;
            end else begin
              st_we    = 1'b1;
              st_waddr = tid_idx;
              st_wdata = ST_DIED;
              if (st_rdata == ST_READY && count != '0) begin
                iter_next  = count;
                found_next = 1'b0;
                state_next = S_RM_RD;
              end else begin
                state_next = S_RM_END;
              end
            end
          end
          default: begin
            err_next = ERR_BAD;
          end
        endcase
      end

      // Removal: rotate the queue once, dropping the first match
      S_RM_RD: begin
        q_raddr    = head;
        state_next = S_RM_WR;
      end

      S_RM_WR: begin
        head_next = head + 1'b1;
        iter_next = iter - 1'b1;
        if (!found && q_rdata == tid_q) begin
          found_next = 1'b1;
          count_next = count - 1'b1;
        end else begin
          q_we    = 1'b1;
          q_waddr = tail;
          q_wdata = q_rdata;
        end
        state_next = (iter == CNT_W'(1)) ? S_RM_END : S_RM_RD;
      end

      S_RM_END: begin
        state_next = resched_q ? S_SCHED_RD : S_DONE;
      end

      // Schedule step: append a running current thread, then pop the head, or run the idle thread if the queue is empty
      S_SCHED_RD: begin
        st_raddr   = cur_idx;
        state_next = S_SCHED_CHK;
      end

      S_SCHED_CHK: begin
        sw_next = 1'b1;
        if (st_rdata == ST_RUNNING) begin
          st_we    = 1'b1;
          st_waddr = cur_idx;
          st_wdata = ST_READY;
          if (room) begin
            q_we       = 1'b1;
            q_waddr    = tail;
            q_wdata    = cur;
            count_next = count + 1'b1;
          end
        end
        state_next = S_SCHED_POP;
      end

      S_SCHED_POP: begin
        if (count == '0) begin
          st_we      = 1'b1;
          st_waddr   = IDX_W'(idle_sel);
          st_wdata   = ST_RUNNING;
          cur_next   = idle_sel;
          state_next = S_DONE;
        end else begin
          q_raddr    = head;
          state_next = S_SCHED_SET;
        end
      end

      S_SCHED_SET: begin
        st_we      = 1'b1;
        st_waddr   = IDX_W'(q_rdata);
        st_wdata   = ST_RUNNING;
        cur_next   = q_rdata;
        head_next  = head + 1'b1;
        count_next = count - 1'b1;
        state_next = S_DONE;
      end

      S_DONE: begin
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Result beat
  assign busy            = (state != S_IDLE);
  assign done            = (state == S_DONE);
  assign active_thread   = cur;
  assign previous_thread = prev;
  assign switched        = sw;
  assign ready_count     = CNT_OUT_W'(count);
  assign error_code      = err;

  // Checks
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= NUM_THREADS)
    else $error("ready queue count above capacity");

  a_error_no_change: assert property (@(posedge clk) disable iff (rst)
    (done && err != ERR_OK) |-> (!sw && cur == prev))
    else $error("failed operation changed the running thread");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted command did not make the block busy");

  a_switch_ok: assert property (@(posedge clk) disable iff (rst)
    (done && sw) |-> (err == ERR_OK))
    else $error("switch reported together with an error");

endmodule

// ===== rtl/core/round_robin_thread_scheduler_top.sv =====
// Top level of the round-robin thread scheduler: register port and stores.
// Path: start, unblock and a status failure step S_DECODE, S_STAT, S_DONE; a bad operation or
// kind steps S_DECODE, S_DONE; a schedule step adds S_SCHED_RD, S_SCHED_CHK, S_SCHED_POP
// and S_SCHED_SET if a thread is popped; exit adds S_RM_END, and S_RM_RD, S_RM_WR per entry if queued.
// Throughput: one operation at a time; a new start is taken the cycle after done.
// Reset: synchronous, valid bits clear at once; the receiver cannot stall.
module round_robin_thread_scheduler_top #(
  parameter int NUM_THREADS = rrts_pkg::NUM_THREADS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // command channel
  input  logic                            start,
  output logic                            busy,
  input  logic [rrts_pkg::OP_W-1:0]       operation,
  input  logic [rrts_pkg::TID_W-1:0]      thread_id,
  input  logic [rrts_pkg::KIND_W-1:0]     block_kind,
  input  logic                            reschedule,
  // result channel
  output logic                            done,
  output logic [rrts_pkg::TID_W-1:0]      active_thread,
  output logic [rrts_pkg::TID_W-1:0]      previous_thread,
  output logic                            switched,
  output logic [rrts_pkg::CNT_OUT_W-1:0]  ready_count,
  output logic [rrts_pkg::ERR_W-1:0]      error_code,
  // register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rrts_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rrts_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rrts_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import rrts_pkg::*;

  localparam int IDX_W = $clog2(NUM_THREADS);
  localparam int CNT_W = $clog2(NUM_THREADS + 1);

  logic [TID_W-1:0] fallback_tid;

  logic              st_we;
  logic [IDX_W-1:0]  st_waddr;
  logic [STAT_W-1:0] st_wdata;
  logic [IDX_W-1:0]  st_raddr;
  logic [STAT_W-1:0] st_rdata;
  logic              q_we;
  logic [IDX_W-1:0]  q_waddr;
  logic [TID_W-1:0]  q_wdata;
  logic [IDX_W-1:0]  q_raddr;
  logic [TID_W-1:0]  q_rdata;

  // Idle thread register, written by a register port beat
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fallback_tid <= TID_W'(1);
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_IDLE) begin
      fallback_tid <= pwdata[TID_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_IDLE) ? CFG_DATA_W'(fallback_tid) : '0;

  rrts_ctrl #(
    .NUM_THREADS (NUM_THREADS),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .operation       (operation),
    .thread_id       (thread_id),
    .block_kind      (block_kind),
    .reschedule      (reschedule),
    .fallback_tid    (fallback_tid),
    .done            (done),
    .active_thread   (active_thread),
    .previous_thread (previous_thread),
    .switched        (switched),
    .ready_count     (ready_count),
    .error_code      (error_code),
    .st_we           (st_we),
    .st_waddr        (st_waddr),
    .st_wdata        (st_wdata),
    .st_raddr        (st_raddr),
    .st_rdata        (st_rdata),
    .q_we            (q_we),
    .q_waddr         (q_waddr),
    .q_wdata         (q_wdata),
    .q_raddr         (q_raddr),
    .q_rdata         (q_rdata)
  );

  rrts_status_mem #(
    .NUM_THREADS (NUM_THREADS),
    .IDX_W       (IDX_W)
  ) u_status (
    .clk   (clk),
    .rst   (rst),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  rrts_queue_mem #(
    .AW (IDX_W)
  ) u_queue (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

endmodule
